[hw/rtl/slcfr_pkg.sv]
// ----------------------------------------------------------------------------
// slcfr_pkg: shared types and constants of the frame receiver
// Field widths, parser phases, event codes, the front-to-back command and
// the byte-wise CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
`default_nettype none

package slcfr_pkg;

	localparam int LEN_W  = 16;
	localparam int PCNT_W = 7;
	localparam int IDX_W  = 6;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int CMDQ_DEPTH      = 2;

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_MSB    = 16'h8000;
	localparam logic [7:0]  SYNC_RESET = 8'hAA;

	localparam logic OP_FEED   = 1'b0;
	localparam logic OP_RESYNC = 1'b1;

	typedef enum logic [2:0] {
		PH_SYNC    = 3'd0,
		PH_SEQ     = 3'd1,
		PH_TYPE    = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_LEN_HI  = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CRC_LO  = 3'd6,
		PH_CRC_HI  = 3'd7
	} ph_t;

	typedef enum logic [1:0] {
		EV_GOOD     = 2'd0,
		EV_CRC      = 2'd1,
		EV_OVERSIZE = 2'd2
	} ev_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_EMIT = 2'd2
	} bk_t;

	typedef struct packed {
		ev_t              kind;
		logic [7:0]       seq;
		logic [7:0]       ftype;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = ((c & CRC_MSB) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/slcfr_ifs.sv]
// ----------------------------------------------------------------------------
// slcfr_ifs: channel interfaces of the frame receiver
// Configuration write channel, received-byte channel and result channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface slcfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] sync_value;
	modport source(output valid, output sync_value, input ready);
	modport sink(input valid, input sync_value, output ready);
endinterface

interface slcfr_feed_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source(output valid, output op, output rx_byte, input ready);
	modport sink(input valid, input op, input rx_byte, output ready);
endinterface

interface slcfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  seq_number;
	logic [7:0]  frame_type;
	logic [15:0] payload_length;
	logic        has_data;
	logic [7:0]  data_byte;
	logic [5:0]  byte_index;
	logic        last_of_run;
	logic [31:0] good_count;
	logic [31:0] crc_error_count;
	logic [31:0] oversize_count;
	modport source(output valid, output event_kind, output seq_number, output frame_type,
		output payload_length, output has_data, output data_byte, output byte_index,
		output last_of_run, output good_count, output crc_error_count,
		output oversize_count, input ready);
	modport sink(input valid, input event_kind, input seq_number, input frame_type,
		input payload_length, input has_data, input data_byte, input byte_index,
		input last_of_run, input good_count, input crc_error_count,
		input oversize_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/sync_length_crc_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver: length-prefixed frame receiver
// Finds the sync byte, parses sequence, type, length, payload and a
// CRC-16/CCITT-FALSE, and reports good payload runs, CRC errors and
// oversize frames with running totals.
//
//   channel  modport  word                              handshake
//   cfg      sink     sync_value                        valid & ready
//   feed     sink     op, rx_byte                       valid & ready
//   result   source   event, header, data, counters     valid & ready
//
// The parser takes one word per cycle unless the command queue is full or
// a run holds it, and updates the CRC in that cycle. A good frame's payload
// leaves as a run of words, each fetched by a registered read of the payload store.
// A payload word of the next frame waits until the previous run has left;
// up to two frame outcomes wait in the command queue between the parts.
// Reset clears parser and counters at once; the payload store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_crc_frame_receiver import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	slcfr_cfg_if.sink      cfg,
	slcfr_feed_if.sink     feed,
	slcfr_result_if.source result
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	cmd_t q_din;
	cmd_t q_dout;
	wr_t  wr;
	logic run_done;

	slcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.feed     (feed),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_din),
		.wr       (wr),
		.run_done (run_done)
	);

	slcfr_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	slcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_cmd    (q_dout),
		.wr       (wr),
		.run_done (run_done),
		.result   (result)
	);

endmodule

`default_nettype wire

[hw/rtl/slcfr_front.sv]
// ----------------------------------------------------------------------------
// slcfr_front: frame parser
// Hunts for the sync byte, collects header, payload and CRC one word per
// cycle while feed.ready is high, updates the CRC per byte and queues one command per frame outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_front import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	slcfr_cfg_if.sink  cfg,
	slcfr_feed_if.sink feed,
	input  logic q_full,
	output logic q_push,
	output cmd_t q_cmd,
	output wr_t  wr,
	input  logic run_done
);

	ph_t              phase_q, phase_d;
	logic [7:0]       sync_q;
	logic [7:0]       seq_q, seq_d;
	logic [7:0]       type_q, type_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [PCNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [15:0]      crc_q, crc_d, crc_next;
	logic [7:0]       crc_lo_q, crc_lo_d;
	logic             run_busy_q;
	logic             accept;
	logic [LEN_W-1:0] len_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		seq_d     = seq_q;
		type_d    = type_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		crc_lo_d  = crc_lo_q;
		q_push    = 1'b0;
		q_cmd     = '{kind: EV_GOOD, seq: seq_q, ftype: type_q, len: len_q};
		wr        = '{en: 1'b0, addr: cnt_q[IDX_W-1:0], data: feed.rx_byte};
		feed.ready = !q_full && !(run_busy_q && (phase_q == PH_PAYLOAD));
		accept    = feed.valid && feed.ready;
		crc_next  = crc16_byte((phase_q == PH_TYPE) ? CRC_INIT : crc_q, feed.rx_byte);
		len_full  = {feed.rx_byte, len_q[7:0]};
		cnt_inc   = cnt_q + PCNT_W'(1);
		if (accept) begin
			if (feed.op == OP_RESYNC) begin
				phase_d = PH_SYNC;
				cnt_d   = '0;
			end else begin
				unique case (phase_q)
					PH_SYNC: begin
						if (feed.rx_byte == sync_q) begin
							phase_d = PH_SEQ;
						end
					end
					PH_SEQ: begin
						seq_d   = feed.rx_byte;
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						type_d  = feed.rx_byte;
						crc_d   = crc_next;
						phase_d = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						len_d   = {8'h00, feed.rx_byte};
						crc_d   = crc_next;
						phase_d = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						len_d = len_full;
						crc_d = crc_next;
						cnt_d = '0;
						if (len_full > LEN_W'(MAX_PAYLOAD)) begin
							q_push     = 1'b1;
							q_cmd.kind = EV_OVERSIZE;
							q_cmd.len  = len_full;
							phase_d    = PH_SYNC;
						end else if (len_full == '0) begin
							phase_d = PH_CRC_LO;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						wr.en = 1'b1;
						crc_d = crc_next;
						cnt_d = cnt_inc;
						if (LEN_W'(cnt_inc) >= len_q) begin
							phase_d = PH_CRC_LO;
						end
					end
					PH_CRC_LO: begin
						crc_lo_d = feed.rx_byte;
						phase_d  = PH_CRC_HI;
					end
					PH_CRC_HI: begin
						q_push     = 1'b1;
						q_cmd.kind = ({feed.rx_byte, crc_lo_q} == crc_q) ? EV_GOOD : EV_CRC;
						phase_d    = PH_SYNC;
						cnt_d      = '0;
					end
					default: begin
						phase_d = PH_SYNC;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sync_q     <= SYNC_RESET;
			run_busy_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (cfg.valid) begin
				sync_q <= cfg.sync_value;
			end
			if (q_push && (q_cmd.kind == EV_GOOD) && (len_q != '0)) begin
				run_busy_q <= 1'b1;
			end else if (run_done) begin
				run_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		seq_q    <= seq_d;
		type_q   <= type_d;
		len_q    <= len_d;
		crc_q    <= crc_d;
		crc_lo_q <= crc_lo_d;
	end

	// The payload store must not be overwritten while a run is being read out.
	a_no_write_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !run_busy_q)
		else $error("payload written while a run is pending");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

endmodule

`default_nettype wire

[hw/rtl/slcfr_cmdq.sv]
// ----------------------------------------------------------------------------
// slcfr_cmdq: command queue
// Short first-in first-out queue of frame outcomes between parser and
// result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_cmdq import slcfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	cmd_t          entry_q [CMDQ_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(CMDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= din;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(CMDQ_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

[hw/rtl/slcfr_back.sv]
// ----------------------------------------------------------------------------
// slcfr_back: result sequencer
// Takes frame outcomes from the queue, keeps the event counters and turns a
// good frame with payload into a run of payload words read from the payload store.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_back import slcfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  cmd_t q_cmd,
	input  wr_t  wr,
	output logic run_done,
	slcfr_result_if.source result
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	bk_t               st_q, st_d;
	cmd_t              cmd_q;
	logic [PCNT_W-1:0] idx_q, idx_d;
	logic [31:0]       good_q, good_d;
	logic [31:0]       crc_err_q, crc_err_d;
	logic [31:0]       over_q, over_d;
	logic [7:0]        mem [MAX_PAYLOAD];
	logic [7:0]        rd_data_q;
	logic              has_data;
	logic              last;

	assign has_data = (cmd_q.kind == EV_GOOD) && (cmd_q.len != '0);
	assign last     = !has_data || ((LEN_W'(idx_q) + LEN_W'(1)) == cmd_q.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d         = st_q;
		idx_d        = idx_q;
		good_d       = good_q;
		crc_err_d    = crc_err_q;
		over_d       = over_q;
		q_pop        = 1'b0;
		run_done     = 1'b0;
		result.valid = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					idx_d = '0;
					case (q_cmd.kind)
						EV_GOOD:     good_d    = good_q + 32'd1;
						EV_CRC:      crc_err_d = crc_err_q + 32'd1;
						EV_OVERSIZE: over_d    = over_q + 32'd1;
						default:     ;
					endcase
					st_d = ((q_cmd.kind == EV_GOOD) && (q_cmd.len != '0)) ? BK_READ : BK_EMIT;
				end
			end
			BK_READ: begin
				st_d = BK_EMIT;
			end
			BK_EMIT: begin
				result.valid = 1'b1;
				if (result.ready) begin
					if (last) begin
						run_done = has_data;
						st_d     = BK_IDLE;
					end else begin
						idx_d = idx_q + PCNT_W'(1);
						st_d  = BK_READ;
					end
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			good_q    <= '0;
			crc_err_q <= '0;
			over_q    <= '0;
		end else begin
			idx_q     <= idx_d;
			good_q    <= good_d;
			crc_err_q <= crc_err_d;
			over_q    <= over_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	assign result.event_kind      = cmd_q.kind;
	assign result.seq_number      = cmd_q.seq;
	assign result.frame_type      = cmd_q.ftype;
	assign result.payload_length  = cmd_q.len;
	assign result.has_data        = has_data;
	assign result.data_byte       = has_data ? rd_data_q : 8'h00;
	assign result.byte_index      = has_data ? idx_q[IDX_W-1:0] : '0;
	assign result.last_of_run     = last;
	assign result.good_count      = good_q;
	assign result.crc_error_count = crc_err_q;
	assign result.oversize_count  = over_q;

	a_index_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == BK_EMIT) && has_data) |-> (LEN_W'(idx_q) < cmd_q.len))
		else $error("payload index beyond frame length");

	a_done_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |-> ((st_q == BK_EMIT) && result.ready && has_data))
		else $error("run released outside its last word");

endmodule

`default_nettype wire

[sim/tb_sync_length_crc_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_crc_frame_receiver: self-checking bench of the frame receiver
// A clocked driver feeds received words from a queue that the stimulus
// process fills with directed frames and random traffic under several sync
// values. Each accepted word runs through a local model of the parser and
// its CRC, and the expected event words are compared field by field with
// what the block emits. Both sides idle at random, and the result side holds
// off once for a long stretch so the block has to stall its input.
// ----------------------------------------------------------------------------

module tb_sync_length_crc_frame_receiver;
	import slcfr_pkg::*;

	localparam int FRAME_MAX    = MAX_PAYLOAD_DEF;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		ev_t         kind;
		logic [7:0]  seq;
		logic [7:0]  ftype;
		logic [15:0] len;
		logic        has;
		logic [7:0]  data;
		logic [5:0]  idx;
		logic        last;
		logic [31:0] good;
		logic [31:0] crc_err;
		logic [31:0] oversize;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;

	slcfr_cfg_if    cfg_ch();
	slcfr_feed_if   feed_ch();
	slcfr_result_if result_ch();

	sync_length_crc_frame_receiver #(.MAX_PAYLOAD(FRAME_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.feed(feed_ch),
		.result(result_ch)
	);

	logic [7:0]  sync_reg;
	ph_t         phase;
	logic [7:0]  hdr_seq;
	logic [7:0]  hdr_type;
	logic [15:0] hdr_len;
	logic [6:0]  body_count;
	logic [15:0] crc_acc;
	logic [7:0]  crc_lo_q;
	logic [7:0]  body_store [64];
	logic [31:0] tot_good;
	logic [31:0] tot_crc;
	logic [31:0] tot_over;

	rx_word_t rx_stream[$];
	report_t  expected_reports[$];

	int words_queued;
	int words_taken;
	int mismatches;
	int quiet_cycles;
	int idle_pct;
	int hold_left;
	bit feed_took;
	bit hold_request;
	bit hold_served;

	always #2 clk = ~clk;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void add_report(input ev_t kind, input logic has, input logic [7:0] data,
		input logic [5:0] idx, input logic last);
		report_t r;
		r.kind     = kind;
		r.seq      = hdr_seq;
		r.ftype    = hdr_type;
		r.len      = hdr_len;
		r.has      = has;
		r.data     = data;
		r.idx      = idx;
		r.last     = last;
		r.good     = tot_good;
		r.crc_err  = tot_crc;
		r.oversize = tot_over;
		expected_reports.push_back(r);
	endfunction

	function automatic void predict_word(input logic op, input logic [7:0] b);
		if (op == OP_RESYNC) begin
			phase      = PH_SYNC;
			body_count = '0;
		end else begin
			case (phase)
				PH_SYNC: begin
					if (b == sync_reg)
						phase = PH_SEQ;
				end
				PH_SEQ: begin
					hdr_seq = b;
					phase   = PH_TYPE;
				end
				PH_TYPE: begin
					hdr_type = b;
					crc_acc  = crc_step(CRC_INIT, b);
					phase    = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					hdr_len = {8'h00, b};
					crc_acc = crc_step(crc_acc, b);
					phase   = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					hdr_len[15:8] = b;
					crc_acc       = crc_step(crc_acc, b);
					body_count    = '0;
					if (int'(hdr_len) > FRAME_MAX) begin
						tot_over = tot_over + 32'd1;
						phase    = PH_SYNC;
						add_report(EV_OVERSIZE, 1'b0, 8'h00, 6'd0, 1'b1);
					end else if (hdr_len == 16'd0) begin
						phase = PH_CRC_LO;
					end else begin
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					body_store[body_count[5:0]] = b;
					crc_acc    = crc_step(crc_acc, b);
					body_count = body_count + 7'd1;
					if ({9'd0, body_count} >= hdr_len)
						phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					crc_lo_q = b;
					phase    = PH_CRC_HI;
				end
				default: begin
					if ({b, crc_lo_q} == crc_acc) begin
						tot_good = tot_good + 32'd1;
						if (hdr_len == 16'd0) begin
							add_report(EV_GOOD, 1'b0, 8'h00, 6'd0, 1'b1);
						end else begin
							for (int i = 0; i < int'(hdr_len); i++)
								add_report(EV_GOOD, 1'b1, body_store[i], 6'(i),
									i == int'(hdr_len) - 1);
						end
					end else begin
						tot_crc = tot_crc + 32'd1;
						add_report(EV_CRC, 1'b0, 8'h00, 6'd0, 1'b1);
					end
					phase      = PH_SYNC;
					body_count = '0;
				end
			endcase
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_word(input logic op, input logic [7:0] b);
		rx_stream.push_back({op, b});
		words_queued++;
	endtask

	// A positive cut shorter than the frame keeps that many words of it and then resyncs.
	task automatic queue_frame(input logic [7:0] seq, input logic [7:0] ftype,
		input logic [15:0] len, input bit bad_crc, input bit sync_first, input int cut);
		rx_word_t    w[$];
		logic [15:0] crc;
		logic [7:0]  b;
		w.push_back({OP_FEED, sync_reg});
		w.push_back({OP_FEED, seq});
		w.push_back({OP_FEED, ftype});
		w.push_back({OP_FEED, len[7:0]});
		w.push_back({OP_FEED, len[15:8]});
		crc = crc_step(crc_step(crc_step(CRC_INIT, ftype), len[7:0]), len[15:8]);
		if (int'(len) <= FRAME_MAX) begin
			for (int i = 0; i < int'(len); i++) begin
				if ((i == 0 && sync_first) || $urandom_range(0, 15) == 0)
					b = sync_reg;
				else
					b = 8'($urandom);
				w.push_back({OP_FEED, b});
				crc = crc_step(crc, b);
			end
			if (bad_crc)
				crc = crc ^ 16'($urandom_range(1, 65535));
			w.push_back({OP_FEED, crc[7:0]});
			w.push_back({OP_FEED, crc[15:8]});
		end
		if (cut > 0 && cut < w.size()) begin
			w = w[0:cut-1];
			w.push_back({OP_RESYNC, 8'($urandom)});
		end
		foreach (w[i])
			queue_word(w[i].op, w[i].rx_byte);
	endtask

	task automatic queue_traffic(input int n_words);
		int         start;
		int         pick;
		int         lsel;
		logic [7:0] b;
		logic [15:0] len;
		start = words_queued;
		while (words_queued - start < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				b = 8'($urandom);
				while (b == sync_reg)
					b = 8'($urandom);
				queue_word(OP_FEED, b);
			end else if (pick < 14) begin
				queue_word(OP_RESYNC, 8'($urandom));
			end else if (pick < 22) begin
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 6)),
					$urandom_range(0, 1), 1'b0, $urandom_range(1, 8));
			end else begin
				lsel = $urandom_range(0, 99);
				if (lsel < 70)
					len = 16'($urandom_range(0, 8));
				else if (lsel < 90)
					len = 16'($urandom_range(9, 24));
				else if (lsel < 95)
					len = ($urandom_range(0, 1) != 0) ? 16'(FRAME_MAX + 1) :
						16'($urandom_range(FRAME_MAX + 1, 65535));
				else
					len = 16'd0;
				queue_frame(8'($urandom), 8'($urandom), len,
					$urandom_range(0, 99) < 15, 1'b0, 0);
			end
		end
	endtask

	task automatic wait_idle();
		while (words_taken != words_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] sync, input int n_words, input int idle,
		input bit hold, input bit full_frame);
		@(posedge clk);
		idle_pct = idle;
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.sync_value <= sync;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		sync_reg = sync;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (full_frame)
			queue_frame(8'($urandom), 8'($urandom), 16'(FRAME_MAX), 1'b0, 1'b1, 0);
		queue_traffic(n_words);
		if (hold)
			hold_request = 1'b1;
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (!feed_ch.valid || feed_took) begin
			if (rx_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				feed_ch.valid   <= 1'b1;
				feed_ch.op      <= rx_stream[0].op;
				feed_ch.rx_byte <= rx_stream[0].rx_byte;
			end else begin
				feed_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request && !hold_served) begin
			hold_left   = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("event_kind", want.kind, result_ch.event_kind);
				check_field("seq_number", want.seq, result_ch.seq_number);
				check_field("frame_type", want.ftype, result_ch.frame_type);
				check_field("payload_length", want.len, result_ch.payload_length);
				check_field("has_data", want.has, result_ch.has_data);
				check_field("data_byte", want.data, result_ch.data_byte);
				check_field("byte_index", want.idx, result_ch.byte_index);
				check_field("last_of_run", want.last, result_ch.last_of_run);
				check_field("good_count", want.good, result_ch.good_count);
				check_field("crc_error_count", want.crc_err, result_ch.crc_error_count);
				check_field("oversize_count", want.oversize, result_ch.oversize_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			feed_took = feed_ch.valid && feed_ch.ready;
			if (feed_took) begin
				predict_word(feed_ch.op, feed_ch.rx_byte);
				void'(rx_stream.pop_front());
				words_taken++;
			end
			if ((feed_ch.valid && feed_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
				(result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.sync_value = 8'h00;
		feed_ch.valid     = 1'b0;
		feed_ch.op        = OP_FEED;
		feed_ch.rx_byte   = 8'h00;
		result_ch.ready   = 1'b0;
		sync_reg          = SYNC_RESET;
		phase             = PH_SYNC;
		hdr_seq           = 8'h00;
		hdr_type          = 8'h00;
		hdr_len           = 16'h0000;
		body_count        = '0;
		crc_acc           = CRC_INIT;
		crc_lo_q          = 8'h00;
		tot_good          = '0;
		tot_crc           = '0;
		tot_over          = '0;
		words_queued      = 0;
		words_taken       = 0;
		mismatches        = 0;
		quiet_cycles      = 0;
		idle_pct          = 36;
		hold_left         = 0;
		feed_took         = 1'b0;
		hold_request      = 1'b0;
		hold_served       = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sync value: noise, resync, oversize, empty frames and a sync
		// byte carried as payload.
		queue_word(OP_FEED, 8'h00);
		queue_word(OP_RESYNC, 8'hFF);
		queue_frame(8'h00, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 0);
		queue_frame(8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0, 0);
		queue_frame(8'h5A, 8'hA5, 16'h0000, 1'b1, 1'b0, 0);
		queue_frame(8'h01, 8'h80, 16'h0001, 1'b0, 1'b1, 0);
		wait_idle();

		run_phase(8'h00, 40, 36, 1'b1, 1'b0);
		run_phase(8'hFF, 35, 0, 1'b0, 1'b0);
		run_phase(8'($urandom_range(1, 254)), 25, 36, 1'b0, 1'b1);

		if (mismatches == 0 && expected_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
